// ===== rtl/btc_pkg.sv =====
package btc_pkg;

  localparam int unsigned CfgDataW = 64;
  localparam int unsigned LenRegW  = 5;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned ByteW    = 8;

  // configuration register indexes
  localparam logic REG_BLOCK_LEN  = 1'b0;
  localparam logic REG_PERM_TABLE = 1'b1;

  localparam logic [ByteW-1:0] PAD_CHAR = 8'd42;

  // controller to datapath
  typedef struct packed {
    logic place_msg;   // write the input word at the current position
    logic place_pad;   // write a pad word at the current position
    logic drain_step;  // move one buffered word into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fill_last;   // current position is the last of the block
    logic drain_last;  // current drain slot is the last of the block
    logic out_free;    // output register can take a word this cycle
  } stat_t;

endpackage

// ===== rtl/btc_ctrl.sv =====
module btc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           msg_end_i,
  output logic           in_ready_o,
  input  btc_pkg::stat_t stat_i,
  output btc_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_FILL,
    ST_PAD,
    ST_DRAIN
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    state_d    = state_q;
    unique case (state_q)
      ST_FILL: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.place_msg = 1'b1;
          if (stat_i.fill_last) begin
            state_d = ST_DRAIN;
          end else if (msg_end_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd_o.place_pad = 1'b1;
        if (stat_i.fill_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat_i.out_free) begin
          cmd_o.drain_step = 1'b1;
          if (stat_i.drain_last) begin
            state_d = ST_FILL;
          end
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/btc_datapath.sv =====
module btc_datapath #(
  parameter int unsigned MAX_BLOCK = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [btc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [btc_pkg::ByteW-1:0]    msg_byte_i,
  input  logic                         msg_end_i,
  input  btc_pkg::cmd_t                cmd_i,
  output btc_pkg::stat_t               stat_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [btc_pkg::ByteW-1:0]    out_byte_o,
  output logic                         block_end_o,
  output logic                         message_end_o
);

  localparam int unsigned IdxW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int unsigned LenW = $clog2(MAX_BLOCK + 1);

  logic [btc_pkg::LenRegW-1:0]  len_q;
  logic [btc_pkg::CfgDataW-1:0] perm_q;
  logic [LenW-1:0]              pos_q;
  logic [LenW-1:0]              drain_q;
  logic                         last_q;
  logic [btc_pkg::ByteW-1:0]    buf_q [MAX_BLOCK];

  logic                         out_valid_q;
  logic [btc_pkg::ByteW-1:0]    out_byte_q;
  logic                         block_end_q;
  logic                         message_end_q;

  logic [LenW-1:0]              eff_len;
  logic [btc_pkg::LenRegW-1:0]  pos_ext;
  logic [btc_pkg::SlotW-1:0]    slot;
  logic                         slot_ok;
  logic [btc_pkg::ByteW-1:0]    wr_byte;
  logic                         wr_en;
  logic [LenW-1:0]              pos_inc;
  logic [LenW-1:0]              drain_inc;

  // zero length acts as one, anything above the buffer saturates
  always_comb begin
    if (len_q == '0) begin
      eff_len = LenW'(1);
    end else if (len_q > btc_pkg::LenRegW'(MAX_BLOCK)) begin
      eff_len = LenW'(MAX_BLOCK);
    end else begin
      eff_len = len_q[LenW-1:0];
    end
  end

  assign pos_ext   = btc_pkg::LenRegW'(pos_q);
  assign slot      = perm_q[pos_ext[btc_pkg::SlotW-1:0] * btc_pkg::SlotW +: btc_pkg::SlotW];
  assign slot_ok   = btc_pkg::LenRegW'(slot) < btc_pkg::LenRegW'(MAX_BLOCK);
  assign wr_byte   = cmd_i.place_pad ? btc_pkg::PAD_CHAR : msg_byte_i;
  assign wr_en     = (cmd_i.place_msg || cmd_i.place_pad) && slot_ok;
  assign pos_inc   = pos_q + LenW'(1);
  assign drain_inc = drain_q + LenW'(1);

  assign stat_o.fill_last  = pos_inc >= eff_len;
  assign stat_o.drain_last = drain_inc >= eff_len;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // slots outside the buffer are dropped
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      buf_q[slot[IdxW-1:0]] <= wr_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= btc_pkg::LenRegW'(16);
      perm_q  <= '0;
      pos_q   <= '0;
      drain_q <= '0;
      last_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          btc_pkg::REG_BLOCK_LEN: begin
            len_q <= cfg_data_i[btc_pkg::LenRegW-1:0];
            pos_q <= '0;
          end
          btc_pkg::REG_PERM_TABLE: perm_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.place_msg || cmd_i.place_pad) begin
        pos_q <= stat_o.fill_last ? '0 : pos_inc;
      end
      if (cmd_i.place_msg) begin
        last_q <= msg_end_i;
      end
      if (cmd_i.drain_step) begin
        drain_q <= stat_o.drain_last ? '0 : drain_inc;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.drain_step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.drain_step) begin
      out_byte_q    <= buf_q[drain_q[IdxW-1:0]];
      block_end_q   <= stat_o.drain_last;
      message_end_q <= stat_o.drain_last && last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign block_end_o   = block_end_q;
  assign message_end_o = message_end_q;

endmodule

// ===== rtl/block_transposition_cipher.sv =====
// channel  direction  handshake                 payload
// cfg      in         cfg_we_i                  cfg_idx_i, cfg_data_i[63:0]
// in       in         in_valid_i / in_ready_o   msg_byte_i[7:0], msg_end_i
// out      out        out_valid_o / out_ready_i out_byte_o[7:0], block_end_o, message_end_o
//
// message words are taken one a cycle while the block fills; the word that completes a
// block, or ends the message, is followed by the missing pad words, one a cycle, and a
// drain of the block from the single-write buffer, one slot a cycle while out is free
// reset is asynchronous and active low; block_len returns to 16, the table to zero
// input is held off during pad and drain; a stalled output holds the drain
module block_transposition_cipher #(
  parameter int unsigned MAX_BLOCK = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [btc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [btc_pkg::ByteW-1:0]    msg_byte_i,
  input  logic                         msg_end_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [btc_pkg::ByteW-1:0]    out_byte_o,
  output logic                         block_end_o,
  output logic                         message_end_o
);

  btc_pkg::cmd_t  cmd;
  btc_pkg::stat_t stat;

  btc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .msg_end_i  (msg_end_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  btc_datapath #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .msg_byte_i    (msg_byte_i),
    .msg_end_i     (msg_end_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .block_end_o   (block_end_o),
    .message_end_o (message_end_o)
  );

endmodule
